/* rtl/core/pen_sample_kinematics_assert.svh */
// Assertion macros shared by the pen sample kinematics RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef PEN_SAMPLE_KINEMATICS_ASSERT_SVH
`define PEN_SAMPLE_KINEMATICS_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PSK_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PSK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/psk_pkg.sv */
// Package for the pen sample kinematics block: action codes, controller states,
// datapath operations, command and status structs and saturation helpers. No dependencies.
package psk_pkg;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_BATCH = 2'd1,
		ACT_REAL  = 2'd2,
		ACT_PRED  = 2'd3
	} psk_act_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_DIST,
		ST_MVX, ST_DVX, ST_WVX, ST_MVY, ST_DVY, ST_WVY,
		ST_MAX, ST_DAX, ST_WAX, ST_MAY, ST_DAY, ST_WAY,
		ST_COMMIT
	} psk_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_ROLLBACK, OP_LOAD, OP_SQX, OP_SQY, OP_ROOT_STEP,
		OP_DIST, OP_MUL_VX, OP_MUL_VY, OP_MUL_AX, OP_MUL_AY, OP_DIV_STEP,
		OP_WR_VX, OP_WR_VY, OP_WR_AX, OP_WR_AY, OP_COMMIT
	} psk_op_t;

	typedef struct packed {
		psk_op_t op;
	} psk_cmd_t;

	typedef struct packed {
		logic have;
		logic dt_pos;
	} psk_stat_t;

	localparam int unsigned ROOT_STEPS = 25;
	localparam int unsigned DIV_STEPS  = 53;
	localparam int unsigned CNT_W      = 6;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

	// Signed velocity from a quotient magnitude, saturated to 32 bits.
	function automatic logic [31:0] sat_vel(input logic neg, input logic [52:0] q);
		logic [31:0] r;
		begin
			if (!neg) begin
				r = (q > 53'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
			end else begin
				r = (q > 53'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
			end
			return r;
		end
	endfunction

	// Signed acceleration from a quotient magnitude, saturated to 40 bits.
	function automatic logic [39:0] sat_acc(input logic neg, input logic [52:0] q);
		logic [39:0] r;
		begin
			if (!neg) begin
				r = (q > 53'h7F_FFFF_FFFF) ? 40'h7F_FFFF_FFFF : q[39:0];
			end else begin
				r = (q > 53'h80_0000_0000) ? 40'h80_0000_0000 : (40'd0 - q[39:0]);
			end
			return r;
		end
	endfunction

endpackage

/* rtl/core/psk_ctrl.sv */
// Controller state machine of the pen sample kinematics block.
// Depends on psk_pkg and pen_sample_kinematics_assert.svh.
`include "pen_sample_kinematics_assert.svh"

module psk_ctrl import psk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  psk_act_t  in_action,
	output logic      in_ready,
	input  logic      out_ready,
	output logic      out_valid,
	input  psk_stat_t stat,
	output psk_cmd_t  cmd
);

	psk_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;
	logic             root_done, div_done, in_div;

	assign slot_free = !out_valid_q || out_ready;
	assign root_done = (cnt_q == CNT_W'(ROOT_STEPS - 1));
	assign div_done  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign in_div    = (state_q inside {ST_DVX, ST_DVY, ST_DAX, ST_DAY});
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && (in_action inside {ACT_REAL, ACT_PRED})) state_d = ST_SQX;
			end
			ST_SQX:    state_d = stat.have ? ST_SQY : ST_COMMIT;
			ST_SQY:    state_d = ST_ROOT;
			ST_ROOT:   if (root_done) state_d = ST_DIST;
			ST_DIST:   state_d = stat.dt_pos ? ST_MVX : ST_COMMIT;
			ST_MVX:    state_d = ST_DVX;
			ST_DVX:    if (div_done) state_d = ST_WVX;
			ST_WVX:    state_d = ST_MVY;
			ST_MVY:    state_d = ST_DVY;
			ST_DVY:    if (div_done) state_d = ST_WVY;
			ST_WVY:    state_d = ST_MAX;
			ST_MAX:    state_d = ST_DAX;
			ST_DAX:    if (div_done) state_d = ST_WAX;
			ST_WAX:    state_d = ST_MAY;
			ST_MAY:    state_d = ST_DAY;
			ST_DAY:    if (div_done) state_d = ST_WAY;
			ST_WAY:    state_d = ST_COMMIT;
			ST_COMMIT: if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_action)
						ACT_START: cmd.op = OP_CLEAR;
						ACT_BATCH: cmd.op = OP_ROLLBACK;
						default:   cmd.op = OP_LOAD;
					endcase
				end
			end
			ST_SQX:    cmd.op = OP_SQX;
			ST_SQY:    cmd.op = OP_SQY;
			ST_ROOT:   cmd.op = OP_ROOT_STEP;
			ST_DIST:   cmd.op = OP_DIST;
			ST_MVX:    cmd.op = OP_MUL_VX;
			ST_MVY:    cmd.op = OP_MUL_VY;
			ST_MAX:    cmd.op = OP_MUL_AX;
			ST_MAY:    cmd.op = OP_MUL_AY;
			ST_DVX, ST_DVY, ST_DAX, ST_DAY: cmd.op = OP_DIV_STEP;
			ST_WVX:    cmd.op = OP_WR_VX;
			ST_WVY:    cmd.op = OP_WR_VY;
			ST_WAX:    cmd.op = OP_WR_AX;
			ST_WAY:    cmd.op = OP_WR_AY;
			ST_COMMIT: cmd.op = slot_free ? OP_COMMIT : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_ROOT || in_div) && state_d == state_q) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.op == OP_COMMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PSK_ASSERT_SAME(a_commit_slot, cmd.op == OP_COMMIT, !out_valid_q || out_ready, "commit into a full output register")
	`PSK_ASSERT_NEXT(a_commit_shows, cmd.op == OP_COMMIT, out_valid_q, "committed result not presented")
	`PSK_ASSERT_SAME(a_div_count, in_div, cnt_q < CNT_W'(DIV_STEPS), "divider step count overrun")
	`PSK_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && (in_action == ACT_REAL || in_action == ACT_PRED), state_q != ST_IDLE, "sample accepted without starting work")

endmodule

/* rtl/core/psk_dp.sv */
// Datapath of the pen sample kinematics block: sample history, square root
// steps, shared divider steps, result and output registers. Depends on psk_pkg.
module psk_dp import psk_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  psk_cmd_t           cmd,
	input  psk_act_t           in_action,
	input  logic signed [23:0] in_x,
	input  logic signed [23:0] in_y,
	input  logic [31:0]        in_t,
	output psk_stat_t          stat,
	output logic [31:0]        out_vx,
	output logic [31:0]        out_vy,
	output logic [39:0]        out_ax,
	output logic [39:0]        out_ay,
	output logic [31:0]        out_dist,
	output logic               out_pred
);

	// Sample history.
	logic               real_valid_q, tip_valid_q;
	logic signed [23:0] real_x_q, real_y_q, tip_x_q, tip_y_q;
	logic [31:0]        real_t_q, tip_t_q, real_dist_q, tip_dist_q;
	logic [31:0]        real_vx_q, real_vy_q, tip_vx_q, tip_vy_q;

	// Working registers.
	logic signed [23:0] cur_x_q, cur_y_q;
	logic [31:0]        cur_t_q, dt_q, rd_q;
	logic [31:0]        pvx_q, pvy_q;
	logic               pred_q, have_q, dt_pos_q;
	logic signed [24:0] dx_q, dy_q;
	logic [49:0]        sq_q;
	logic [24:0]        root_q;
	logic [26:0]        rem_q;
	logic [52:0]        num_q;
	logic [31:0]        drem_q;
	logic               neg_q;
	logic [31:0]        vx_q, vy_q, dist_q;
	logic [39:0]        ax_q, ay_q;

	// Output register.
	logic [31:0] out_vx_q, out_vy_q, out_dist_q;
	logic [39:0] out_ax_q, out_ay_q;
	logic        out_pred_q;

	// Reference selection at load.
	logic               use_real;
	logic               ref_valid;
	logic signed [23:0] ref_x, ref_y;
	logic [31:0]        ref_t;
	logic [32:0]        dt_full;

	// Arithmetic.
	logic signed [49:0] sq_prod;
	logic [28:0]        rem_sh, trial;
	logic               root_ge;
	logic [32:0]        dist_sum;
	logic [32:0]        mul_src;
	logic               mul_neg;
	logic signed [32:0] acc_diff;
	logic [52:0]        mul_prod;
	logic [32:0]        dsh;
	logic               div_ge;

	assign use_real  = (in_action == ACT_REAL);
	assign ref_valid = use_real ? real_valid_q : tip_valid_q;
	assign ref_x     = use_real ? real_x_q : tip_x_q;
	assign ref_y     = use_real ? real_y_q : tip_y_q;
	assign ref_t     = use_real ? real_t_q : tip_t_q;
	assign dt_full   = {1'b0, in_t} - {1'b0, ref_t};

	assign sq_prod = (cmd.op == OP_SQX) ? dx_q * dx_q : dy_q * dy_q;

	assign rem_sh  = {rem_q, sq_q[49:48]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign root_ge = (rem_sh >= trial);

	assign dist_sum = {1'b0, rd_q} + {8'd0, root_q};

	always_comb begin
		acc_diff = '0;
		mul_src  = '0;
		mul_neg  = 1'b0;
		case (cmd.op)
			OP_MUL_VX: begin
				mul_neg = dx_q[24];
				mul_src = {8'd0, (dx_q[24] ? 25'(-dx_q) : 25'(dx_q))};
			end
			OP_MUL_VY: begin
				mul_neg = dy_q[24];
				mul_src = {8'd0, (dy_q[24] ? 25'(-dy_q) : 25'(dy_q))};
			end
			OP_MUL_AX: begin
				acc_diff = $signed({vx_q[31], vx_q}) - $signed({pvx_q[31], pvx_q});
				mul_neg  = acc_diff[32];
				mul_src  = acc_diff[32] ? 33'(-acc_diff) : 33'(acc_diff);
			end
			OP_MUL_AY: begin
				acc_diff = $signed({vy_q[31], vy_q}) - $signed({pvy_q[31], pvy_q});
				mul_neg  = acc_diff[32];
				mul_src  = acc_diff[32] ? 33'(-acc_diff) : 33'(acc_diff);
			end
			default: begin
				mul_src = '0;
			end
		endcase
	end

	assign mul_prod = 53'(mul_src * USEC_PER_SEC);

	assign dsh    = {drem_q, num_q[52]};
	assign div_ge = (dsh >= {1'b0, dt_q});

	// History registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_valid_q <= 1'b0;
			real_x_q     <= '0;
			real_y_q     <= '0;
			real_t_q     <= '0;
			real_vx_q    <= '0;
			real_vy_q    <= '0;
			real_dist_q  <= '0;
			tip_valid_q  <= 1'b0;
			tip_x_q      <= '0;
			tip_y_q      <= '0;
			tip_t_q      <= '0;
			tip_vx_q     <= '0;
			tip_vy_q     <= '0;
			tip_dist_q   <= '0;
		end else begin
			case (cmd.op)
				OP_CLEAR: begin
					real_valid_q <= 1'b0;
					real_x_q     <= '0;
					real_y_q     <= '0;
					real_t_q     <= '0;
					real_vx_q    <= '0;
					real_vy_q    <= '0;
					real_dist_q  <= '0;
					tip_valid_q  <= 1'b0;
					tip_x_q      <= '0;
					tip_y_q      <= '0;
					tip_t_q      <= '0;
					tip_vx_q     <= '0;
					tip_vy_q     <= '0;
					tip_dist_q   <= '0;
				end
				OP_ROLLBACK: begin
					tip_valid_q <= real_valid_q;
					tip_x_q     <= real_x_q;
					tip_y_q     <= real_y_q;
					tip_t_q     <= real_t_q;
					tip_vx_q    <= real_vx_q;
					tip_vy_q    <= real_vy_q;
					tip_dist_q  <= real_dist_q;
				end
				OP_COMMIT: begin
					if (!pred_q) begin
						real_valid_q <= 1'b1;
						real_x_q     <= cur_x_q;
						real_y_q     <= cur_y_q;
						real_t_q     <= cur_t_q;
						real_vx_q    <= vx_q;
						real_vy_q    <= vy_q;
						real_dist_q  <= dist_q;
					end
					tip_valid_q <= 1'b1;
					tip_x_q     <= cur_x_q;
					tip_y_q     <= cur_y_q;
					tip_t_q     <= cur_t_q;
					tip_vx_q    <= vx_q;
					tip_vy_q    <= vy_q;
					tip_dist_q  <= dist_q;
				end
				default: begin
					tip_valid_q <= tip_valid_q;
				end
			endcase
		end
	end

	// Working and output registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cur_x_q  <= in_x;
				cur_y_q  <= in_y;
				cur_t_q  <= in_t;
				pred_q   <= (in_action == ACT_PRED);
				have_q   <= ref_valid;
				dx_q     <= 25'(in_x) - 25'(ref_x);
				dy_q     <= 25'(in_y) - 25'(ref_y);
				dt_q     <= dt_full[31:0];
				dt_pos_q <= !dt_full[32] && (dt_full[31:0] != 32'd0);
				rd_q     <= use_real ? real_dist_q : tip_dist_q;
				pvx_q    <= use_real ? real_vx_q : tip_vx_q;
				pvy_q    <= use_real ? real_vy_q : tip_vy_q;
				vx_q     <= '0;
				vy_q     <= '0;
				ax_q     <= '0;
				ay_q     <= '0;
				dist_q   <= '0;
			end
			OP_SQX: sq_q <= $unsigned(sq_prod);
			OP_SQY: begin
				sq_q   <= sq_q + $unsigned(sq_prod);
				root_q <= '0;
				rem_q  <= '0;
			end
			OP_ROOT_STEP: begin
				rem_q  <= root_ge ? 27'(rem_sh - trial) : rem_sh[26:0];
				root_q <= {root_q[23:0], root_ge};
				sq_q   <= {sq_q[47:0], 2'b00};
			end
			OP_DIST: dist_q <= dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];
			OP_MUL_VX, OP_MUL_VY, OP_MUL_AX, OP_MUL_AY: begin
				num_q  <= mul_prod;
				neg_q  <= mul_neg;
				drem_q <= '0;
			end
			OP_DIV_STEP: begin
				drem_q <= div_ge ? 32'(dsh - {1'b0, dt_q}) : dsh[31:0];
				num_q  <= {num_q[51:0], div_ge};
			end
			OP_WR_VX: vx_q <= sat_vel(neg_q, num_q);
			OP_WR_VY: vy_q <= sat_vel(neg_q, num_q);
			OP_WR_AX: ax_q <= sat_acc(neg_q, num_q);
			OP_WR_AY: ay_q <= sat_acc(neg_q, num_q);
			OP_COMMIT: begin
				out_vx_q   <= vx_q;
				out_vy_q   <= vy_q;
				out_ax_q   <= ax_q;
				out_ay_q   <= ay_q;
				out_dist_q <= dist_q;
				out_pred_q <= pred_q;
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

	assign stat.have   = have_q;
	assign stat.dt_pos = dt_pos_q;
	assign out_vx      = out_vx_q;
	assign out_vy      = out_vy_q;
	assign out_ax      = out_ax_q;
	assign out_ay      = out_ay_q;
	assign out_dist    = out_dist_q;
	assign out_pred    = out_pred_q;

endmodule

/* rtl/core/pen_sample_kinematics.sv */
// Top level of the pen sample kinematics block: finite-difference path length,
// velocity and acceleration of pen samples. Depends on psk_pkg, psk_ctrl and psk_dp.
//
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   x_position 24, y_position 24, sample_time 32  action 2
// m_axis   out  velocity_x 32, velocity_y 32, accel_x 40,    is_predicted 1
//               accel_y 40, path_length 32
//
// Start-stroke and begin-batch beats give no result. A sample beat runs one
// load, two squaring steps, 25 square root steps and, when time advances,
// four divisions (multiply, 53 restoring quotient steps, saturate) on the
// shared divider. A sample with no earlier reference goes straight to commit.
// The input is ready only while the controller is idle; the finished result
// waits in the output register, so the next beat is accepted while it is unread.
// Reset clears the sample history and control state; no clearing pass is needed.
module pen_sample_kinematics import psk_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [79:0]  s_axis_tdata,  // x_position, y_position, sample_time
	input  logic [1:0]   s_axis_tuser,  // action
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [175:0] m_axis_tdata,  // velocity_x, velocity_y, accel_x, accel_y, path_length
	output logic         m_axis_tuser   // is_predicted
);

	psk_cmd_t    cmd;
	psk_stat_t   stat;
	psk_act_t    action;
	logic [31:0] vx, vy, path_len;
	logic [39:0] ax, ay;

	assign action = psk_act_t'(s_axis_tuser);

	// The controller sequences the datapath one operation per cycle, holding at commit while the output register is full.
	psk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (action),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath keeps the real and tip history and computes the results.
	psk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_action (action),
		.in_x      ($signed(s_axis_tdata[23:0])),
		.in_y      ($signed(s_axis_tdata[47:24])),
		.in_t      (s_axis_tdata[79:48]),
		.stat      (stat),
		.out_vx    (vx),
		.out_vy    (vy),
		.out_ax    (ax),
		.out_ay    (ay),
		.out_dist  (path_len),
		.out_pred  (m_axis_tuser)
	);

	assign m_axis_tdata = {path_len, ay, ax, vy, vx};

endmodule
